FILE: rtl/bkd_pkg.sv
// ----------------------------------------------------------------------------
// bkd_pkg
// Shared types, constants and the character table of the base-24 key decoder.
// ----------------------------------------------------------------------------
package bkd_pkg;

    localparam logic [6:0] START_OFFSET = 7'd52;
    localparam logic [6:0] KEY_END      = 7'd67;   // first offset past the key bytes
    localparam logic [6:0] MIN_RECORD   = 7'd77;   // offset of key start plus key chars
    localparam int         KEY_BYTES    = 15;
    localparam int         KEY_CHARS    = 25;
    localparam logic [3:0] KEY_LAST_IDX = 4'd14;
    localparam logic [4:0] CHAR_LAST    = 5'd24;
    localparam logic [2:0] GROUP_LEN    = 3'd5;
    localparam logic [4:0] RADIX        = 5'd24;
    localparam logic [6:0] CHAR_N       = 7'h4E;
    localparam logic [6:0] CHAR_HYPHEN  = 7'h2D;
    localparam int         FLAG_BIT     = 3;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_DIV,
        ST_EMIT
    } bkd_state_t;

    // one step of the long division: quotient byte and remainder
    typedef struct packed {
        logic [7:0] quot;
        logic [4:0] rem;
    } bkd_div_t;

    // base-24 digit to ascii; codes past 23 wrap modulo 24
    function automatic logic [6:0] bkd_alphabet(input logic [4:0] digit);
        logic [6:0] code;
        case (digit)
            5'd0, 5'd24:  code = 7'h42;  // B
            5'd1, 5'd25:  code = 7'h43;  // C
            5'd2, 5'd26:  code = 7'h44;  // D
            5'd3, 5'd27:  code = 7'h46;  // F
            5'd4, 5'd28:  code = 7'h47;  // G
            5'd5, 5'd29:  code = 7'h48;  // H
            5'd6, 5'd30:  code = 7'h4A;  // J
            5'd7, 5'd31:  code = 7'h4B;  // K
            5'd8:         code = 7'h4D;  // M
            5'd9:         code = 7'h50;  // P
            5'd10:        code = 7'h51;  // Q
            5'd11:        code = 7'h52;  // R
            5'd12:        code = 7'h54;  // T
            5'd13:        code = 7'h56;  // V
            5'd14:        code = 7'h57;  // W
            5'd15:        code = 7'h58;  // X
            5'd16:        code = 7'h59;  // Y
            5'd17:        code = 7'h32;  // 2
            5'd18:        code = 7'h33;  // 3
            5'd19:        code = 7'h34;  // 4
            5'd20:        code = 7'h36;  // 6
            5'd21:        code = 7'h37;  // 7
            5'd22:        code = 7'h38;  // 8
            default:      code = 7'h39;  // 9
        endcase
        return code;
    endfunction

endpackage

FILE: rtl/bkd_div24.sv
// ----------------------------------------------------------------------------
// bkd_div24
// Divides a remainder-prefixed key byte by 24: reciprocal estimate, one fixup.
// ----------------------------------------------------------------------------
module bkd_div24 (
    input  logic [4:0]        rem_in,
    input  logic [7:0]        byte_in,
    output bkd_pkg::bkd_div_t result
);
    import bkd_pkg::*;

    logic [12:0] acc;
    logic [9:0]  acc_div8;
    logic [18:0] prod;
    logic [8:0]  q_est;
    logic [12:0] r_full;
    logic [5:0]  r_est;

    // acc < 24 * 256, so acc / 24 fits in a byte
    assign acc      = {rem_in, byte_in};
    assign acc_div8 = acc[12:3];
    // 341 / 1024 sits just under 1/3: the estimate is exact or one low
    assign prod     = acc_div8 * 9'd341;
    assign q_est    = prod[18:10];
    assign r_full   = acc - {q_est, 4'b0000} - {1'b0, q_est, 3'b000};
    assign r_est    = r_full[5:0];

    always_comb begin
        if (r_est >= {1'b0, RADIX}) begin
            result.quot = q_est[7:0] + 8'd1;
            result.rem  = 5'(r_est - {1'b0, RADIX});
        end else begin
            result.quot = q_est[7:0];
            result.rem  = r_est[4:0];
        end
    end

endmodule

FILE: rtl/bkd_char_fmt.sv
// ----------------------------------------------------------------------------
// bkd_char_fmt
// Picks the digit for a key position and forms the ascii code of a result.
// ----------------------------------------------------------------------------
module bkd_char_fmt (
    input  logic [4:0] char_idx,
    input  logic       new_format,
    input  logic       hyphen,
    output logic [4:0] digit_sel,
    input  logic [4:0] digit,
    output logic [6:0] code
);
    import bkd_pkg::*;

    logic shifted;
    logic insert_n;

    // new format drops the leftmost digit and puts N in position five
    assign shifted   = new_format && (char_idx < 5'(GROUP_LEN));
    assign insert_n  = new_format && (char_idx == 5'(GROUP_LEN));
    assign digit_sel = shifted ? char_idx + 5'd1 : char_idx;

    always_comb begin
        if (hyphen) begin
            code = CHAR_HYPHEN;
        end else if (insert_n) begin
            code = CHAR_N;
        end else begin
            code = bkd_alphabet(digit);
        end
    end

endmodule

FILE: rtl/base24_product_key_decoder.sv
// ----------------------------------------------------------------------------
// base24_product_key_decoder
// Decodes the base-24 product key out of a streamed product-id record.
// ----------------------------------------------------------------------------
// Record bytes are taken one per cycle while loading, as long as the output register
// is free. A final byte of a record shorter than 77 bytes gives one empty result at
// once. A final byte of a longer record starts the decode: one shared divide-by-24
// unit walks the 15 key bytes for each of the 25 digits, one byte per cycle, and then
// the 29 characters leave at one per cycle as fast as the sink takes them. The input
// is not ready during decode and emit.
module base24_product_key_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] record_byte
    input  logic       s_tlast,   // end_of_record
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] char_code, [7] zero
    output logic       m_tuser,   // key_empty
    output logic       m_tlast    // last_char
);
    import bkd_pkg::*;

    bkd_state_t state_reg, state_next;

    logic [6:0] bytes_seen_reg, bytes_seen_next;
    logic [7:0] key_reg   [KEY_BYTES];
    logic [7:0] key_next  [KEY_BYTES];
    logic [4:0] digit_reg [KEY_CHARS];
    logic [4:0] digit_next[KEY_CHARS];
    logic       flag_reg, flag_next;
    logic [3:0] div_j_reg, div_j_next;
    logic [4:0] div_i_reg, div_i_next;
    logic [4:0] rem_reg, rem_next;
    logic [4:0] char_idx_reg, char_idx_next;
    logic [2:0] grp_pos_reg, grp_pos_next;
    logic       m_valid_reg, m_valid_next;
    logic [6:0] m_code_reg, m_code_next;
    logic       m_empty_reg, m_empty_next;
    logic       m_last_reg, m_last_next;

    logic       in_accept;
    logic       out_free;
    logic [6:0] pos_inc;
    logic       long_record;
    logic       in_key;
    logic [6:0] key_off;
    logic       div_done;
    logic       emit_fire;
    logic       hyphen;
    logic       emit_last;
    logic [4:0] digit_sel;
    logic [6:0] fmt_code;
    bkd_div_t   div_res;

    bkd_div24 u_div (
        .rem_in  (rem_reg),
        .byte_in (key_reg[div_j_reg]),
        .result  (div_res)
    );

    bkd_char_fmt u_fmt (
        .char_idx   (char_idx_reg),
        .new_format (flag_reg),
        .hyphen     (hyphen),
        .digit_sel  (digit_sel),
        .digit      (digit_reg[digit_sel]),
        .code       (fmt_code)
    );

    assign out_free    = !m_valid_reg || m_tready;
    assign in_accept   = s_tvalid && s_tready;
    assign pos_inc     = (bytes_seen_reg < MIN_RECORD) ? bytes_seen_reg + 7'd1 : bytes_seen_reg;
    assign long_record = (pos_inc == MIN_RECORD);
    assign in_key      = (bytes_seen_reg >= START_OFFSET) && (bytes_seen_reg < KEY_END);
    assign key_off     = bytes_seen_reg - START_OFFSET;
    assign div_done    = (div_j_reg == 4'd0) && (div_i_reg == 5'd0);
    assign hyphen      = (grp_pos_reg == GROUP_LEN);
    assign emit_last   = (char_idx_reg == CHAR_LAST) && !hyphen;
    assign emit_fire   = (state_reg == ST_EMIT) && out_free;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (in_accept && s_tlast && long_record) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_fire && emit_last) begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // datapath and outputs
    always_comb begin
        bytes_seen_next = bytes_seen_reg;
        key_next        = key_reg;
        digit_next      = digit_reg;
        flag_next       = flag_reg;
        div_j_next      = div_j_reg;
        div_i_next      = div_i_reg;
        rem_next        = rem_reg;
        char_idx_next   = char_idx_reg;
        grp_pos_next    = grp_pos_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_code_next     = m_code_reg;
        m_empty_next    = m_empty_reg;
        m_last_next     = m_last_reg;
        s_tready        = 1'b0;

        unique case (state_reg)
            ST_LOAD: begin
                s_tready = out_free;
                if (in_accept) begin
                    if (in_key) begin
                        key_next[key_off[3:0]] = s_tdata;
                    end
                    bytes_seen_next = s_tlast ? 7'd0 : pos_inc;
                    if (s_tlast && !long_record) begin
                        m_valid_next = 1'b1;
                        m_code_next  = 7'd0;
                        m_empty_next = 1'b1;
                        m_last_next  = 1'b1;
                    end else if (s_tlast) begin
                        // top key byte was stored long before the final byte
                        flag_next = key_reg[KEY_LAST_IDX][FLAG_BIT];
                        key_next[KEY_LAST_IDX][FLAG_BIT] = 1'b0;
                        div_j_next    = KEY_LAST_IDX;
                        div_i_next    = CHAR_LAST;
                        rem_next      = 5'd0;
                        char_idx_next = 5'd0;
                        grp_pos_next  = 3'd0;
                    end
                end
            end
            ST_DIV: begin
                key_next[div_j_reg] = div_res.quot;
                if (div_j_reg == 4'd0) begin
                    digit_next[div_i_reg] = div_res.rem;
                    rem_next   = 5'd0;
                    div_j_next = KEY_LAST_IDX;
                    div_i_next = div_i_reg - 5'd1;
                end else begin
                    rem_next   = div_res.rem;
                    div_j_next = div_j_reg - 4'd1;
                end
            end
            ST_EMIT: begin
                if (emit_fire) begin
                    m_valid_next = 1'b1;
                    m_code_next  = fmt_code;
                    m_empty_next = 1'b0;
                    m_last_next  = emit_last;
                    if (hyphen) begin
                        grp_pos_next = 3'd0;
                    end else begin
                        grp_pos_next  = grp_pos_reg + 3'd1;
                        char_idx_next = char_idx_reg + 5'd1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            bytes_seen_reg <= 7'd0;
            flag_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            bytes_seen_reg <= bytes_seen_next;
            flag_reg       <= flag_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg      <= key_next;
        digit_reg    <= digit_next;
        div_j_reg    <= div_j_next;
        div_i_reg    <= div_i_next;
        rem_reg      <= rem_next;
        char_idx_reg <= char_idx_next;
        grp_pos_reg  <= grp_pos_next;
        m_code_reg   <= m_code_next;
        m_empty_reg  <= m_empty_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_code_reg};
    assign m_tuser  = m_empty_reg;
    assign m_tlast  = m_last_reg;

endmodule

FILE: rtl/bkd_checker.sv
// ----------------------------------------------------------------------------
// bkd_checker
// Port-level checks of the key decoder, bound to the top level.
// ----------------------------------------------------------------------------
module bkd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("stalled result changed");

    // an empty key is a single zero result
    a_empty_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata == 8'd0))
        else $error("empty result malformed");

    // no request is taken while a result is stuck in the output register
    a_no_take_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !(m_tvalid && !m_tready))
        else $error("input ready while output stalled");

    // the key is still being sent while a non-final character is shown
    a_busy_mid_key: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready in the middle of a key");

endmodule

bind base24_product_key_decoder bkd_checker u_bkd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

FILE: tb/tb_base24_product_key_decoder.sv
// ----------------------------------------------------------------------------
// tb_base24_product_key_decoder
// Self-checking bench for the base-24 product key decoder.
// ----------------------------------------------------------------------------
// Product-id records are streamed in byte by byte. A behavioral model keeps its
// own key bytes and byte count, and on each final byte it works out the 120-bit
// long division and the 29-character key text, or the single empty result of a
// short record. Every character that leaves the block is checked against the
// oldest expected one. A table of directed records (record length limits, zero and
// all-ones keys, format flag, count saturation) runs first, then random records
// under three handshake pressure patterns.
// ----------------------------------------------------------------------------
module tb_base24_product_key_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import bkd_pkg::*;

    typedef struct packed {
        logic [6:0] code;
        logic       empty;
        logic       last;
    } key_char_t;

    typedef enum logic [1:0] {
        CHECK_MODEL,
        CHECK_EMPTY,
        CHECK_ZERO_KEY
    } row_check_t;

    typedef struct packed {
        logic [7:0] len;
        logic [7:0] body;
        logic [7:0] top;
        logic       rand_key;
        row_check_t chk;
    } record_row_t;

    localparam int                 DIRECTED_ROWS    = 12;
    localparam int                 KEY_TEXT_LEN     = 29;
    localparam logic [8*24-1:0]    KEY_ALPHABET     = "BCDFGHJKMPQRTVWXY2346789";
    localparam logic [8*29-1:0]    PLAIN_ZERO_KEY   = "BBBBB-BBBBB-BBBBB-BBBBB-BBBBB";
    localparam logic [8*29-1:0]    FLAGGED_ZERO_KEY = "BBBBB-NBBBB-BBBBB-BBBBB-BBBBB";

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;

    // model state
    logic [7:0] key_mem [0:KEY_BYTES-1];
    int         rec_pos;
    logic       new_fmt;
    key_char_t  model_out [$];
    key_char_t  pending_chars [$];

    int src_idle_pct;
    int snk_idle_pct;
    int errors;

    base24_product_key_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [6:0] glyph(input logic [4:0] digit);
        logic [7:0] ch;
        ch = KEY_ALPHABET[8*(23-digit) +: 8];
        return ch[6:0];
    endfunction

    function automatic record_row_t directed_row(input int idx);
        record_row_t row;
        case (idx)
            0:       row = '{8'd1,   8'h00, 8'h00, 1'b0, CHECK_EMPTY};
            1:       row = '{8'd52,  8'hFF, 8'hFF, 1'b0, CHECK_EMPTY};
            2:       row = '{8'd67,  8'hFF, 8'hFF, 1'b0, CHECK_EMPTY};
            3:       row = '{8'd76,  8'h00, 8'h00, 1'b1, CHECK_EMPTY};
            4:       row = '{8'd77,  8'h00, 8'h00, 1'b0, CHECK_ZERO_KEY};
            5:       row = '{8'd77,  8'h00, 8'h08, 1'b0, CHECK_ZERO_KEY};
            6:       row = '{8'd77,  8'hFF, 8'hFF, 1'b0, CHECK_MODEL};
            7:       row = '{8'd78,  8'hFF, 8'hF7, 1'b0, CHECK_MODEL};
            8:       row = '{8'd77,  8'h00, 8'hF7, 1'b0, CHECK_MODEL};
            9:       row = '{8'd200, 8'h00, 8'h00, 1'b1, CHECK_MODEL};
            10:      row = '{8'd2,   8'h00, 8'h00, 1'b0, CHECK_EMPTY};
            default: row = '{8'd90,  8'h55, 8'hAA, 1'b0, CHECK_MODEL};
        endcase
        return row;
    endfunction

    function automatic logic [119:0] random_key();
        logic [127:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom};
        return bits[119:0];
    endfunction

    // one accepted record byte: updates the model and fills model_out
    task automatic decode_byte(input logic [7:0] b, input logic last);
        logic [119:0] num;
        logic [4:0]   digit [0:KEY_CHARS-1];
        logic [6:0]   text  [0:KEY_CHARS-1];
        int           i;
        model_out.delete();
        if (rec_pos >= START_OFFSET && rec_pos < KEY_END) begin
            key_mem[rec_pos - START_OFFSET] = b;
        end
        if (rec_pos < MIN_RECORD) begin
            rec_pos++;
        end
        if (last) begin
            if (rec_pos < MIN_RECORD) begin
                model_out.push_back(key_char_t'{7'd0, 1'b1, 1'b1});
            end else begin
                new_fmt = key_mem[KEY_BYTES-1][FLAG_BIT];
                key_mem[KEY_BYTES-1][FLAG_BIT] = 1'b0;
                for (i = 0; i < KEY_BYTES; i++) begin
                    num[8*i +: 8] = key_mem[i];
                end
                // first remainder is the rightmost character
                for (i = KEY_CHARS - 1; i >= 0; i--) begin
                    digit[i] = 5'(num % 24);
                    num = num / 24;
                end
                for (i = 0; i < KEY_CHARS; i++) begin
                    if (!new_fmt) begin
                        text[i] = glyph(digit[i]);
                    end else if (i < GROUP_LEN) begin
                        text[i] = glyph(digit[i+1]);
                    end else if (i == GROUP_LEN) begin
                        text[i] = CHAR_N;
                    end else begin
                        text[i] = glyph(digit[i]);
                    end
                end
                for (i = 0; i < KEY_CHARS; i++) begin
                    if (i > 0 && (i % GROUP_LEN) == 0) begin
                        model_out.push_back(key_char_t'{CHAR_HYPHEN, 1'b0, 1'b0});
                    end
                    model_out.push_back(key_char_t'{text[i], 1'b0, i == KEY_CHARS - 1});
                end
            end
            rec_pos = 0;
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last,
                             input row_check_t chk, input logic flagged);
        logic [8*29-1:0] typed;
        int              i;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        decode_byte(b, last);
        if (last) begin
            case (chk)
                CHECK_EMPTY: begin
                    pending_chars.push_back(key_char_t'{7'd0, 1'b1, 1'b1});
                end
                CHECK_ZERO_KEY: begin
                    typed = flagged ? FLAGGED_ZERO_KEY : PLAIN_ZERO_KEY;
                    for (i = 0; i < KEY_TEXT_LEN; i++) begin
                        pending_chars.push_back(key_char_t'{typed[8*(28-i) +: 7], 1'b0,
                                                            i == KEY_TEXT_LEN - 1});
                    end
                end
                default: begin
                    foreach (model_out[i]) pending_chars.push_back(model_out[i]);
                end
            endcase
        end
        @(negedge aclk);
    endtask

    task automatic send_record(input int len, input logic [119:0] key, input row_check_t chk);
        int         p;
        logic [7:0] b;
        for (p = 0; p < len; p++) begin
            if (p >= START_OFFSET && p < KEY_END) begin
                b = key[8*(p-START_OFFSET) +: 8];
            end else begin
                b = 8'($urandom);
            end
            send_byte(b, p == len - 1, chk, key[119-4]);
        end
    endtask

    // hold the request side until every pending character has come out
    task automatic drain_pending();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_chars.size() != 0) @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge aclk) begin : check_chars
        key_char_t seen;
        key_char_t want;
        if (aresetn && m_tvalid && m_tready) begin
            seen = key_char_t'{m_tdata[6:0], m_tuser, m_tlast};
            // compare on the falling edge so same-edge model updates have landed
            @(negedge aclk);
            if (pending_chars.size() == 0) begin
                $error("unexpected char: char_code %0h key_empty %0b last_char %0b",
                       seen.code, seen.empty, seen.last);
                errors++;
            end else begin
                want = pending_chars.pop_front();
                if (seen.code !== want.code) begin
                    $error("char_code: expected %0h, got %0h", want.code, seen.code);
                    errors++;
                end
                if (seen.empty !== want.empty) begin
                    $error("key_empty: expected %0b, got %0b", want.empty, seen.empty);
                    errors++;
                end
                if (seen.last !== want.last) begin
                    $error("last_char: expected %0b, got %0b", want.last, seen.last);
                    errors++;
                end
            end
        end
    end

    initial begin : stimulus
        record_row_t  row;
        logic [119:0] key;
        int           r;
        int           k;
        int           phase;
        int           len;
        int           ph_items;
        int           ph_long;
        errors       = 0;
        rec_pos      = 0;
        new_fmt      = 1'b0;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = 8'h00;
        s_tlast      = 1'b0;
        m_tready     = 1'b0;
        src_idle_pct = 25;
        snk_idle_pct = 55;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        for (r = 0; r < DIRECTED_ROWS; r++) begin
            row = directed_row(r);
            if (row.rand_key) begin
                key = random_key();
            end else begin
                for (k = 0; k < KEY_BYTES - 1; k++) key[8*k +: 8] = row.body;
                key[119:112] = row.top;
            end
            send_record(row.len, key, row.chk);
        end
        drain_pending();

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin src_idle_pct = 25; snk_idle_pct = 55; end
                1:       begin src_idle_pct = 55; snk_idle_pct = 25; end
                default: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
            endcase
            ph_items = 0;
            ph_long  = 0;
            while (ph_items < 40 || ph_long < 2) begin
                // mostly decodable records, some cut short
                if ($urandom_range(4) == 0) begin
                    len = $urandom_range(76, 1);
                end else if ($urandom_range(9) == 0) begin
                    len = $urandom_range(200, 101);
                end else begin
                    len = $urandom_range(100, 77);
                end
                send_record(len, random_key(), CHECK_MODEL);
                ph_items += len;
                if (len >= MIN_RECORD) ph_long++;
            end
            drain_pending();
        end

        // catch anything the block emits after the last expected char
        repeat (500) @(negedge aclk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
